@@ src/sm83_alu_with_flags_macros.svh @@
// Assertion macros used by the ALU stream wrapper.
`ifndef SM83_ALU_WITH_FLAGS_MACROS_SVH
`define SM83_ALU_WITH_FLAGS_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SM83_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition is followed by a result in the next cycle.
`define SM83_ASSERT_NEXT(lbl, pre, post, msg) \
    `SM83_ASSERT_CLK(lbl, (pre) |=> (post), msg)

`endif

@@ src/sm83_pkg.sv @@
// Types, widths and constants shared by the SM83 ALU modules.
package sm83_pkg;

    localparam int KindW   = 5;
    localparam int ValueW  = 8;
    localparam int WideW   = 16;
    localparam int BitIdxW = 3;
    localparam int FlagW   = 4;

    localparam int InDataW  = 56;
    localparam int OutDataW = 32;

    // flag positions within a flag nibble
    localparam int FlagZ = 3;
    localparam int FlagN = 2;
    localparam int FlagH = 1;
    localparam int FlagC = 0;

    localparam logic [7:0]  DaaLimit  = 8'h99;
    localparam logic [7:0]  DaaHiAdj  = 8'h60;
    localparam logic [7:0]  DaaLoAdj  = 8'h06;
    localparam logic [3:0]  DigitMax  = 4'h9;
    localparam logic [3:0]  NibbleMax = 4'hF;

    typedef enum logic [KindW-1:0] {
        OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_XOR, OP_OR, OP_CP,
        OP_INC8, OP_DEC8, OP_INC16, OP_DEC16, OP_ADDHL, OP_ADDSP,
        OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
        OP_RLCA, OP_RRCA, OP_RLA, OP_RRA, OP_DAA, OP_CPL, OP_CCF,
        OP_BIT, OP_RES, OP_SET
    } op_t;

    // request payload, last field in the lowest bits
    typedef struct packed {
        logic [FlagW-1:0]   flags_in;
        logic [BitIdxW-1:0] bit_index;
        logic [WideW-1:0]   wide_operand;
        logic [WideW-1:0]   wide_base;
        logic [ValueW-1:0]  operand;
        logic [ValueW-1:0]  acc;
    } in_data_t;

    typedef struct packed {
        op_t      kind;
        in_data_t data;
    } alu_req_t;

    typedef struct packed {
        logic [FlagW-1:0]  flags_out;
        logic [WideW-1:0]  wide_out;
        logic [ValueW-1:0] value_out;
    } alu_res_t;

endpackage

@@ src/sm83_alu_with_flags.sv @@
// SM83 ALU with Z/N/H/C flags: request register, combinational datapath, result register.
// An accepted request is held in the request register; its result and m_tvalid are loaded
// into the result register once that register is empty or being taken.
// Throughput: one request per cycle unless stalled; both registers advance together when the
// result register is empty or being taken, so a request is taken while a result waits.
// Reset: synchronous on aresetn low; both stages empty, data registers are not cleared.
`include "sm83_alu_with_flags_macros.svh"

module sm83_alu_with_flags (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // acc[7:0], operand[15:8], wide_base[31:16], wide_operand[47:32],
    // bit_index[50:48], flags_in[54:51], zero fill [55]
    input  logic [sm83_pkg::InDataW-1:0]  s_tdata,
    // kind[4:0]
    input  logic [sm83_pkg::KindW-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // value_out[7:0], wide_out[23:8], flags_out[27:24], zero fill [31:28]
    output logic [sm83_pkg::OutDataW-1:0] m_tdata
);
    import sm83_pkg::*;

    localparam int ReqW = $bits(in_data_t);
    localparam int ResW = $bits(alu_res_t);

    alu_req_t s_req;
    alu_req_t s1_req_reg;
    alu_req_t s1_req_next;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    alu_res_t alu_res;
    alu_res_t m_res_reg;
    alu_res_t m_res_next;
    logic     m_valid_reg;
    logic     m_valid_next;
    logic     out_advance;
    logic     s_accept;

    assign s_req.kind = op_t'(s_tuser);
    assign s_req.data = in_data_t'(s_tdata[ReqW-1:0]);

    assign out_advance = !m_valid_reg || m_tready;
    assign s_tready    = !s1_valid_reg || out_advance;
    assign s_accept    = s_tvalid && s_tready;

    sm83_alu u_alu (
        .req (s1_req_reg),
        .res (alu_res)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_req_next   = s1_req_reg;
        m_valid_next  = m_valid_reg;
        m_res_next    = m_res_reg;
        if (s_tready) begin
            s1_valid_next = s_tvalid;
        end
        if (s_accept) begin
            s1_req_next = s_req;
        end
        if (out_advance) begin
            m_valid_next = s1_valid_reg;
            if (s1_valid_reg) begin
                m_res_next = alu_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_req_reg <= s1_req_next;
        m_res_reg  <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OutDataW - ResW){1'b0}}, m_res_reg};

    `SM83_ASSERT_NEXT(a_accept_fills, s_accept, s1_valid_reg, "accepted request lost")
    `SM83_ASSERT_NEXT(a_stage_hold, s1_valid_reg && !out_advance,
        s1_valid_reg && $stable(s1_req_reg), "held request changed")
    `SM83_ASSERT_CLK(a_no_overrun, s1_valid_reg && m_valid_reg && !m_tready |-> !s_tready,
        "request taken into a full pipeline")
    `SM83_ASSERT_NEXT(a_and_sets_h, s1_valid_reg && out_advance && (s1_req_reg.kind == OP_AND),
        m_valid_reg && m_res_reg.flags_out[FlagH], "and result without H flag")

endmodule

@@ src/sm83_alu.sv @@
// Combinational SM83 ALU datapath: one request in, one result out.
module sm83_alu (
    input  sm83_pkg::alu_req_t req,
    output sm83_pkg::alu_res_t res
);
    import sm83_pkg::*;

    logic [7:0]  a;
    logic [7:0]  v;
    logic [15:0] wb;
    logic [15:0] wo;
    logic [2:0]  bi;
    logic [3:0]  fi;
    logic        fc;
    logic        fh;
    logic        fn;
    logic        fz;

    logic        add_cin;
    logic        sub_cin;
    logic [8:0]  add_sum;
    logic [4:0]  add_half;
    logic [8:0]  sub_diff;
    logic [4:0]  sub_half;
    logic [7:0]  inc8_r;
    logic [7:0]  dec8_r;
    logic [16:0] hl_sum;
    logic [12:0] hl_half;
    logic [15:0] sp_sum;
    logic [4:0]  sp_half;
    logic [8:0]  sp_low;
    logic [7:0]  bit_mask;
    logic        daa_hi;
    logic [7:0]  daa_r1;
    logic        daa_lo;
    logic [7:0]  daa_add_r;
    logic [7:0]  daa_sub_r;
    logic [7:0]  daa_r;
    logic [7:0]  logic_and;
    logic [7:0]  logic_xor;
    logic [7:0]  logic_or;

    logic [7:0]  r;
    logic [15:0] w;
    logic [3:0]  f;

    assign a  = req.data.acc;
    assign v  = req.data.operand;
    assign wb = req.data.wide_base;
    assign wo = req.data.wide_operand;
    assign bi = req.data.bit_index;
    assign fi = req.data.flags_in;
    assign fc = fi[FlagC];
    assign fh = fi[FlagH];
    assign fn = fi[FlagN];
    assign fz = fi[FlagZ];

    assign add_cin  = (req.kind == OP_ADC) && fc;
    assign sub_cin  = (req.kind == OP_SBC) && fc;
    assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, add_cin};
    assign add_half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, add_cin};
    assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, sub_cin};
    assign sub_half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, sub_cin};
    assign inc8_r   = v + 8'd1;
    assign dec8_r   = v - 8'd1;
    assign hl_sum   = {1'b0, wb} + {1'b0, wo};
    assign hl_half  = {1'b0, wb[11:0]} + {1'b0, wo[11:0]};
    assign sp_sum   = wb + {{8{v[7]}}, v};
    assign sp_half  = {1'b0, wb[3:0]} + {1'b0, v[3:0]};
    assign sp_low   = {1'b0, wb[7:0]} + {1'b0, v};
    assign bit_mask = 8'd1 << bi;

    assign logic_and = a & v;
    assign logic_xor = a ^ v;
    assign logic_or  = a | v;

    assign daa_hi    = fc || (a > DaaLimit);
    assign daa_r1    = daa_hi ? (a + DaaHiAdj) : a;
    assign daa_lo    = fh || (daa_r1[3:0] > DigitMax);
    assign daa_add_r = daa_lo ? (daa_r1 + DaaLoAdj) : daa_r1;
    assign daa_sub_r = a - (fc ? DaaHiAdj : 8'd0) - (fh ? DaaLoAdj : 8'd0);
    assign daa_r     = fn ? daa_sub_r : daa_add_r;

    always_comb begin
        r = '0;
        w = '0;
        f = fi;
        case (req.kind)
            OP_ADD, OP_ADC: begin
                r = add_sum[7:0];
                f = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
            end
            OP_SUB, OP_SBC: begin
                r = sub_diff[7:0];
                f = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
            end
            OP_CP: begin
                r = a;
                f = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
            end
            OP_AND: begin
                r = logic_and;
                f = {logic_and == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR: begin
                r = logic_xor;
                f = {logic_xor == 8'd0, 3'b000};
            end
            OP_OR: begin
                r = logic_or;
                f = {logic_or == 8'd0, 3'b000};
            end
            OP_INC8: begin
                r = inc8_r;
                f = {inc8_r == 8'd0, 1'b0, inc8_r[3:0] == 4'd0, fc};
            end
            OP_DEC8: begin
                r = dec8_r;
                f = {dec8_r == 8'd0, 1'b1, dec8_r[3:0] == NibbleMax, fc};
            end
            OP_INC16: w = wb + 16'd1;
            OP_DEC16: w = wb - 16'd1;
            OP_ADDHL: begin
                w = hl_sum[15:0];
                f = {fz, 1'b0, hl_half[12], hl_sum[16]};
            end
            OP_ADDSP: begin
                w = sp_sum;
                f = {2'b00, sp_half[4], sp_low[8]};
            end
            OP_RLC: begin
                r = {v[6:0], v[7]};
                f = {r == 8'd0, 2'b00, v[7]};
            end
            OP_RRC: begin
                r = {v[0], v[7:1]};
                f = {r == 8'd0, 2'b00, v[0]};
            end
            OP_RL: begin
                r = {v[6:0], fc};
                f = {r == 8'd0, 2'b00, v[7]};
            end
            OP_RR: begin
                r = {fc, v[7:1]};
                f = {r == 8'd0, 2'b00, v[0]};
            end
            OP_SLA: begin
                r = {v[6:0], 1'b0};
                f = {r == 8'd0, 2'b00, v[7]};
            end
            OP_SRA: begin
                r = {v[7], v[7:1]};
                f = {r == 8'd0, 2'b00, v[0]};
            end
            OP_SWAP: begin
                r = {v[3:0], v[7:4]};
                f = {r == 8'd0, 3'b000};
            end
            OP_SRL: begin
                r = {1'b0, v[7:1]};
                f = {r == 8'd0, 2'b00, v[0]};
            end
            OP_RLCA: begin
                r = {a[6:0], a[7]};
                f = {3'b000, a[7]};
            end
            OP_RRCA: begin
                r = {a[0], a[7:1]};
                f = {3'b000, a[0]};
            end
            OP_RLA: begin
                r = {a[6:0], fc};
                f = {3'b000, a[7]};
            end
            OP_RRA: begin
                r = {fc, a[7:1]};
                f = {3'b000, a[0]};
            end
            OP_DAA: begin
                r = daa_r;
                f = {daa_r == 8'd0, fn, 1'b0, fn ? fc : daa_hi};
            end
            OP_CPL: begin
                r = ~a;
                f = {fz, 1'b1, 1'b1, fc};
            end
            OP_CCF: begin
                r = a;
                f = {fz, 1'b0, 1'b0, ~fc};
            end
            OP_BIT: begin
                r = v;
                f = {~v[bi], 1'b0, 1'b1, fc};
            end
            OP_RES: r = v & ~bit_mask;
            OP_SET: r = v | bit_mask;
            default: begin
                r = '0;
                w = '0;
                f = fi;
            end
        endcase
    end

    assign res.value_out = r;
    assign res.wide_out  = w;
    assign res.flags_out = f;

endmodule

@@ verif/tb.sv @@
// Self-checking stream testbench for the SM83 ALU, with random idling and long back-pressure.
module tb;
    import sm83_pkg::*;

    localparam int LongHold = 150;

    localparam logic [FlagW-1:0] MaskZ = 4'(1 << FlagZ);
    localparam logic [FlagW-1:0] MaskN = 4'(1 << FlagN);
    localparam logic [FlagW-1:0] MaskH = 4'(1 << FlagH);
    localparam logic [FlagW-1:0] MaskC = 4'(1 << FlagC);

    typedef struct {
        op_t      kind;
        alu_res_t res;
    } alu_due_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata  = '0;
    logic [KindW-1:0]    s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;

    alu_due_t alu_results_due[$];
    int       send_idle_pct   = 0;
    int       recv_stall_pct  = 0;
    int       hold_len        = 0;
    int       requests_sent   = 0;
    int       results_checked = 0;
    int       mismatches      = 0;

    sm83_alu_with_flags dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // flag nibble is {Z, N, H, C}
    function automatic alu_res_t sm83_result(input op_t kind, input in_data_t d);
        alu_res_t    res;
        logic [8:0]  sum9;
        logic [4:0]  sum5;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [7:0]  src;
        logic [7:0]  r;
        logic [15:0] w;
        logic [3:0]  f;
        logic        cin;
        logic        cuse;
        logic        cout;
        cin  = d.flags_in[FlagC];
        cuse = (kind == OP_ADC || kind == OP_SBC) && cin;
        r    = '0;
        w    = '0;
        f    = d.flags_in;
        cout = 1'b0;
        src  = (kind >= OP_RLCA && kind <= OP_RRA) ? d.acc : d.operand;
        case (kind)
            OP_ADD, OP_ADC: begin
                sum9 = {1'b0, d.acc} + {1'b0, d.operand} + {8'h00, cuse};
                sum5 = {1'b0, d.acc[3:0]} + {1'b0, d.operand[3:0]} + {4'h0, cuse};
                r    = sum9[7:0];
                f    = {r == 8'h00, 1'b0, sum5[4], sum9[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                sum9 = {1'b0, d.operand} + {8'h00, cuse};
                sum5 = {1'b0, d.operand[3:0]} + {4'h0, cuse};
                r    = d.acc - d.operand - {7'h00, cuse};
                f    = {r == 8'h00, 1'b1, sum5 > {1'b0, d.acc[3:0]}, sum9 > {1'b0, d.acc}};
                if (kind == OP_CP) r = d.acc;
            end
            OP_AND: begin
                r = d.acc & d.operand;
                f = {r == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR, OP_OR: begin
                r = (kind == OP_XOR) ? (d.acc ^ d.operand) : (d.acc | d.operand);
                f = {r == 8'h00, 3'b000};
            end
            OP_INC8: begin
                r = d.operand + 8'd1;
                f = {r == 8'h00, 1'b0, r[3:0] == 4'h0, cin};
            end
            OP_DEC8: begin
                r = d.operand - 8'd1;
                f = {r == 8'h00, 1'b1, r[3:0] == NibbleMax, cin};
            end
            OP_INC16: w = d.wide_base + 16'd1;
            OP_DEC16: w = d.wide_base - 16'd1;
            OP_ADDHL: begin
                sum17 = {1'b0, d.wide_base} + {1'b0, d.wide_operand};
                sum13 = {1'b0, d.wide_base[11:0]} + {1'b0, d.wide_operand[11:0]};
                w     = sum17[15:0];
                f     = {d.flags_in[FlagZ], 1'b0, sum13[12], sum17[16]};
            end
            OP_ADDSP: begin
                w    = d.wide_base + {{8{d.operand[7]}}, d.operand};
                sum5 = {1'b0, d.wide_base[3:0]} + {1'b0, d.operand[3:0]};
                sum9 = {1'b0, d.wide_base[7:0]} + {1'b0, d.operand};
                f    = {2'b00, sum5[4], sum9[8]};
            end
            OP_RLC, OP_RLCA: begin
                r    = {src[6:0], src[7]};
                cout = src[7];
            end
            OP_RRC, OP_RRCA: begin
                r    = {src[0], src[7:1]};
                cout = src[0];
            end
            OP_RL, OP_RLA: begin
                r    = {src[6:0], cin};
                cout = src[7];
            end
            OP_RR, OP_RRA: begin
                r    = {cin, src[7:1]};
                cout = src[0];
            end
            OP_SLA: begin
                r    = {src[6:0], 1'b0};
                cout = src[7];
            end
            OP_SRA: begin
                r    = {src[7], src[7:1]};
                cout = src[0];
            end
            OP_SWAP: r = {src[3:0], src[7:4]};
            OP_SRL: begin
                r    = {1'b0, src[7:1]};
                cout = src[0];
            end
            OP_DAA: begin
                r = d.acc;
                f = {1'b0, d.flags_in[FlagN], 1'b0, d.flags_in[FlagC]};
                if (!d.flags_in[FlagN]) begin
                    if (d.flags_in[FlagC] || r > DaaLimit) begin
                        r        = r + DaaHiAdj;
                        f[FlagC] = 1'b1;
                    end
                    if (d.flags_in[FlagH] || r[3:0] > DigitMax) r = r + DaaLoAdj;
                end else begin
                    if (d.flags_in[FlagC]) r = r - DaaHiAdj;
                    if (d.flags_in[FlagH]) r = r - DaaLoAdj;
                end
                f[FlagZ] = (r == 8'h00);
            end
            OP_CPL: begin
                r = ~d.acc;
                f = {d.flags_in[FlagZ], 2'b11, d.flags_in[FlagC]};
            end
            OP_CCF: begin
                r = d.acc;
                f = {d.flags_in[FlagZ], 2'b00, ~cin};
            end
            OP_BIT: begin
                r = d.operand;
                f = {~d.operand[d.bit_index], 1'b0, 1'b1, cin};
            end
            OP_RES: r = d.operand & ~(8'd1 << d.bit_index);
            default: r = d.operand | (8'd1 << d.bit_index);
        endcase
        if (kind >= OP_RLC && kind <= OP_SRL) f = {r == 8'h00, 2'b00, cout};
        if (kind >= OP_RLCA && kind <= OP_RRA) f = {3'b000, cout};
        res.value_out = r;
        res.wide_out  = w;
        res.flags_out = f;
        return res;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h0F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0FFF;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(input op_t kind, input in_data_t fields);
        alu_due_t due;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, fields};
        do @(posedge aclk); while (!s_tready);
        due.kind = kind;
        due.res  = sm83_result(kind, fields);
        alu_results_due.push_back(due);
        requests_sent++;
    endtask

    task automatic send_fields(input op_t kind, input logic [7:0] acc, input logic [7:0] operand,
                               input logic [15:0] wbase, input logic [15:0] wop,
                               input logic [2:0] bidx, input logic [3:0] flags);
        in_data_t fields;
        fields.acc          = acc;
        fields.operand      = operand;
        fields.wide_base    = wbase;
        fields.wide_operand = wop;
        fields.bit_index    = bidx;
        fields.flags_in     = flags;
        send_request(kind, fields);
    endtask

    task automatic send_random_request();
        send_fields(op_t'(5'($urandom_range(31))), pick_byte(), pick_byte(), pick_word(),
                    pick_word(), 3'($urandom_range(7)), 4'($urandom_range(15)));
    endtask

    task automatic test_every_op();
        for (int i = 0; i < 32; i++) begin
            case (i % 4)
                0: send_fields(op_t'(i), 8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'h0);
                1: send_fields(op_t'(i), 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF);
                2: send_fields(op_t'(i), 8'h0F, 8'h80, 16'h0FFF, 16'h0001, 3'd7, MaskN | MaskC);
                default: send_fields(op_t'(i), 8'h99, 8'h01, 16'hFFFF, 16'hF001, 3'd0,
                                     MaskZ | MaskH);
            endcase
        end
    endtask

    task automatic test_special_cases();
        // decimal adjust after add and after subtract
        send_fields(OP_DAA, 8'h9A, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'h0);
        send_fields(OP_DAA, 8'h11, 8'h00, 16'h0000, 16'h0000, 3'd0, MaskH);
        send_fields(OP_DAA, 8'h9F, 8'h00, 16'h0000, 16'h0000, 3'd0, MaskC);
        send_fields(OP_DAA, 8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, MaskN | MaskH | MaskC);
        send_fields(OP_DAA, 8'h45, 8'h00, 16'h0000, 16'h0000, 3'd0, MaskN);
        // signed offset on SP, carries from the low byte, then carry and flag edge cases of other ops
        send_fields(OP_ADDSP, 8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, MaskZ | MaskN);
        send_fields(OP_ADDSP, 8'h00, 8'h01, 16'h00FF, 16'h0000, 3'd0, 4'h0);
        send_fields(OP_ADDSP, 8'h00, 8'h80, 16'hFFF8, 16'h0000, 3'd0, 4'h0);
        send_fields(OP_ADDHL, 8'h00, 8'h00, 16'h0FFF, 16'h0001, 3'd0, MaskZ);
        send_fields(OP_ADDHL, 8'h00, 8'h00, 16'h8000, 16'h8000, 3'd0, 4'h0);
        send_fields(OP_ADC, 8'hFF, 8'h00, 16'h0000, 16'h0000, 3'd0, MaskC);
        send_fields(OP_SBC, 8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, MaskC);
        send_fields(OP_CP, 8'h3C, 8'h3C, 16'h0000, 16'h0000, 3'd0, 4'h0);
        send_fields(OP_INC8, 8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, MaskC);
        send_fields(OP_DEC8, 8'h00, 8'h10, 16'h0000, 16'h0000, 3'd0, 4'h0);
        send_fields(OP_DEC8, 8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, MaskC);
        send_fields(OP_BIT, 8'h00, 8'h7F, 16'h0000, 16'h0000, 3'd7, MaskC);
        send_fields(OP_RLA, 8'h80, 8'h00, 16'h0000, 16'h0000, 3'd0, MaskZ);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_request();
    endtask

    task automatic test_backpressure();
        hold_len = LongHold;
        repeat (30) send_random_request();
    endtask

    always @(negedge aclk) begin
        if (hold_len > 0) begin
            m_tready <= 1'b0;
            hold_len--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        alu_due_t due;
        alu_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(alu_res_t)-1:0];
            if (alu_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with no request outstanding: %h", m_tdata);
            end else begin
                due = alu_results_due.pop_front();
                results_checked++;
                if (got.value_out !== due.res.value_out || got.wide_out !== due.res.wide_out ||
                    got.flags_out !== due.res.flags_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on %s: expected value %h wide %h flags %b, got value %h wide %h flags %b",
                                 due.kind.name(), due.res.value_out, due.res.wide_out,
                                 due.res.flags_out, got.value_out, got.wide_out, got.flags_out);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        send_idle_pct  = 29;
        recv_stall_pct = 54;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_every_op();
        test_special_cases();
        test_random(220);

        send_idle_pct  = 54;
        recv_stall_pct = 29;
        test_random(220);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();
        test_random(200);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (int n = 0; n < 2000 && alu_results_due.size() != 0; n++) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (alu_results_due.size() != 0)
            $display("%0d results never arrived", alu_results_due.size());
        $display("Covered %0d requests over all 32 opcodes, three idle mixes and a %0d-cycle stall.",
                 requests_sent, LongHold);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && alu_results_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sm83_alu_with_flags.f @@
+incdir+src
src/sm83_pkg.sv
src/sm83_alu.sv
src/sm83_alu_with_flags.sv
verif/tb.sv
